// ===== hdl/bcd_pkg.sv =====
// types, constants and table function shared by the box-cox derivative pipeline
`timescale 1ns / 1ps
package bcd_pkg;

  localparam int LOG_BITS = 24;
  localparam int DIV_BITS = 32;
  localparam int EXP_BITS = 20;
  localparam int E_STAGE  = LOG_BITS + 1;
  localparam int N_STAGES = E_STAGE + EXP_BITS;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONPOS = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;

  localparam logic [2:0] REG_LAMBDA0 = 3'd0;
  localparam logic [2:0] REG_SHIFT0  = 3'd4;

  // front stage: shifted value and lambda
  typedef struct packed {
    logic               vld;
    logic               last;
    logic signed [15:0] lam;
    logic signed [32:0] xs;
  } front_t;

  // record carried through the log / divide / exp stages
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               neg;
    logic               xone;
    logic               near;
    logic signed [15:0] lam;
    logic [31:0]        xr;
    logic [4:0]         p;
    logic [30:0]        m;
    logic [23:0]        frac;
    logic [31:0]        rem;
    logic [31:0]        quo;
    logic signed [9:0]  n;
    logic [19:0]        f;
    logic [30:0]        acc;
  } pipe_t;

  // 2^(2^-k) in q1.30 by repeated integer square root
  function automatic logic [30:0] root_q30(input int k);
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    t = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      v = t << 30;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      t = r;
    end
    return t[30:0];
  endfunction

endpackage

// ===== hdl/bcd_stage.sv =====
// one register stage of the log, divide, exponent multiply and exp chain
`timescale 1ns / 1ps
module bcd_stage import bcd_pkg::*; #(
  parameter int IDX = 1
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  pipe_t d,
  output pipe_t q
);

  localparam int K = IDX - E_STAGE;
  localparam logic [30:0] ROOT = root_q30(K);
  // exponent fraction bit tested by this stage, kept in range outside the exp stages
  localparam int FB = (K >= 1 && K <= EXP_BITS) ? EXP_BITS - K : 0;

  pipe_t nxt;
  logic [61:0] sq;
  logic [31:0] sqh;
  logic [32:0] dt;
  logic signed [16:0] lam_m1;
  logic signed [28:0] lg;
  logic signed [45:0] prod;
  logic [61:0] ap;

  always_comb begin
    nxt    = d;
    sq     = '0;
    sqh    = '0;
    dt     = '0;
    lam_m1 = '0;
    lg     = '0;
    prod   = '0;
    ap     = '0;
    // log2 fraction bit by squaring
    if (IDX >= 1 && IDX <= LOG_BITS) begin
      sq  = {31'd0, d.m} * {31'd0, d.m};
      sqh = sq[61:30];
      if (sqh[31]) begin
        nxt.m    = sqh[31:1];
        nxt.frac = {d.frac[22:0], 1'b1};
      end else begin
        nxt.m    = sqh[30:0];
        nxt.frac = {d.frac[22:0], 1'b0};
      end
    end
    // restoring divide of 2^32 by x, one quotient bit
    if (IDX >= 1 && IDX <= DIV_BITS) begin
      dt = {d.rem, 1'b0};
      if (dt >= {1'b0, d.xr}) begin
        nxt.rem = 32'(dt - {1'b0, d.xr});
        nxt.quo = {d.quo[30:0], 1'b1};
      end else begin
        nxt.rem = dt[31:0];
        nxt.quo = {d.quo[30:0], 1'b0};
      end
    end
    // exponent (lambda-1)*log2 x in q.36
    if (IDX == E_STAGE) begin
      lam_m1   = 17'({d.lam[15], d.lam}) - 17'sd4096;
      lg       = {d.p ^ 5'h10, d.frac};
      prod     = 46'(lam_m1) * 46'(lg);
      nxt.n    = prod[45:36];
      nxt.f    = prod[35:16];
      nxt.near = (d.lam == 16'sd0) || (d.p == 5'd16 && d.frac == 24'd0);
      nxt.acc  = 31'd1 << 30;
    end
    // product of roots of two
    if (IDX > E_STAGE && IDX <= N_STAGES) begin
      if (d.f[FB]) begin
        ap      = {31'd0, d.acc} * {31'd0, ROOT};
        nxt.acc = ap[60:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (adv) begin
      q <= nxt;
    end
  end

endmodule

// ===== hdl/box_cox_derivative.sv =====
// box-cox transform derivative, fixed point, fully pipelined
// pipeline registers from input accept to output valid: front add, normalize,
//   24 log2 squaring stages, exponent multiply, 20 exp stages, output register
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// reset (synchronous, active high) clears all valid bits and loads lambda = 1.0
//   and shift = 0 for every component
`timescale 1ns / 1ps
module box_cox_derivative import bcd_pkg::*; #(
  parameter int DIMENSION = 4
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_value,
  input  logic [1:0]         component,
  input  logic               last_in,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        derivative,
  output logic [1:0]         status,
  output logic               last_out,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] CMAX = 2'(DIMENSION - 1);

  // configuration registers
  logic signed [15:0] lambda [4];
  logic signed [31:0] shift  [4];
  logic [2:0]         ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        lambda[i] <= 16'sd4096;
        shift[i]  <= 32'sd0;
      end
    end else if (psel && penable && pwrite) begin
      if (ridx < REG_SHIFT0) begin
        lambda[ridx[1:0]] <= pwdata[15:0];
      end else begin
        shift[ridx[1:0]] <= pwdata;
      end
    end
  end

  always_comb begin
    if (ridx < REG_SHIFT0) begin
      prdata = {16'd0, lambda[ridx[1:0] - REG_LAMBDA0[1:0]]};
    end else begin
      prdata = shift[ridx[1:0]];
    end
  end

  // global advance: everything moves unless the output item is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // front stage: pick registers of the component, add the shift
  logic [1:0] csel;
  front_t     fr;
  assign csel = (component > CMAX) ? CMAX : component;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr.vld <= 1'b0;
    end else if (adv) begin
      fr.vld  <= in_valid;
      fr.last <= last_in;
      fr.lam  <= lambda[csel];
      fr.xs   <= 33'(sample_value) + 33'(shift[csel]);
    end
  end

  // normalize stage: top bit position and mantissa in q1.30
  pipe_t       stg [N_STAGES + 1];
  pipe_t       nb;
  logic [4:0]  pos;
  logic [61:0] mw;

  always_comb begin
    pos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (fr.xs[i]) pos = 5'(i);
    end
    mw        = {fr.xs[31:0], 30'd0} >> pos;
    nb        = '0;
    nb.vld    = fr.vld;
    nb.last   = fr.last;
    nb.neg    = fr.xs[32] || (fr.xs == 33'sd0);
    nb.xone   = (fr.xs == 33'sd1);
    nb.lam    = fr.lam;
    nb.xr     = fr.xs[31:0];
    nb.p      = pos;
    nb.m      = mw[30:0];
    nb.rem    = 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].vld <= 1'b0;
    end else if (adv) begin
      stg[0] <= nb;
    end
  end

  // log, divide and exp chain
  for (genvar j = 1; j <= N_STAGES; j++) begin : g_stage
    bcd_stage #(.IDX(j)) u_stage (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (stg[j - 1]),
      .q   (stg[j])
    );
  end

  // result selection: error, saturation, reciprocal branch or power branch
  pipe_t              fin;
  logic signed [10:0] sexp;
  logic [4:0]         rsh;
  logic [31:0]        pw;
  logic [31:0]        d_next;
  logic [1:0]         st_next;

  assign fin = stg[N_STAGES];

  always_comb begin
    sexp    = 11'(fin.n) + 11'sd16;
    rsh     = 5'(11'sd31 - sexp);
    pw      = {fin.acc, 1'b0} >> rsh;
    d_next  = 32'd0;
    st_next = ST_OK;
    if (fin.neg) begin
      st_next = ST_NONPOS;
    end else if (fin.near) begin
      if (fin.xone) begin
        d_next  = 32'hFFFF_FFFF;
        st_next = ST_SAT;
      end else begin
        d_next = fin.quo;
      end
    end else if (sexp >= 11'sd32) begin
      d_next  = 32'hFFFF_FFFF;
      st_next = ST_SAT;
    end else if (sexp >= 11'sd0) begin
      d_next = pw;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid  <= fin.vld;
      derivative <= d_next;
      status     <= st_next;
      last_out   <= fin.last;
    end
  end

endmodule
